### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define A32_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, masked while reset is high.
`define A32_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define A32_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/a32enc_pkg.sv
// Package of the A32 encoder: operation kinds, item types and fixed opcode words.
`default_nettype none
package a32enc_pkg;

   typedef enum logic [5:0] {
      KIND_LOAD    = 6'd0,
      KIND_LOAD8   = 6'd1,
      KIND_LOADS8  = 6'd2,
      KIND_LOAD16  = 6'd3,
      KIND_LOADS16 = 6'd4,
      KIND_STORE   = 6'd5,
      KIND_STORE8  = 6'd6,
      KIND_STORE16 = 6'd7,
      KIND_MOVE    = 6'd8,
      KIND_ADD     = 6'd9,
      KIND_SUB     = 6'd10,
      KIND_AND     = 6'd11,
      KIND_OR      = 6'd12,
      KIND_XOR     = 6'd13,
      KIND_SHL     = 6'd14,
      KIND_SHR     = 6'd15,
      KIND_SAR     = 6'd16,
      KIND_ROL     = 6'd17,
      KIND_ROR     = 6'd18,
      KIND_CMP     = 6'd19,
      KIND_NOT     = 6'd20,
      KIND_SELEQ   = 6'd21,
      KIND_SELGE   = 6'd22,
      KIND_SELGT   = 6'd23,
      KIND_SELGES  = 6'd24,
      KIND_SELGTS  = 6'd25,
      KIND_BRA     = 6'd26,
      KIND_BNE     = 6'd27,
      KIND_BEQ     = 6'd28,
      KIND_BG      = 6'd29,
      KIND_BLE     = 6'd30,
      KIND_BL      = 6'd31,
      KIND_BGE     = 6'd32,
      KIND_DIV     = 6'd33,
      KIND_DIVS    = 6'd34,
      KIND_MUL     = 6'd35,
      KIND_SWI     = 6'd36,
      KIND_BKPT    = 6'd37
   } kind_type;

   typedef struct packed {
      logic [5:0]  req_type;
      logic [3:0]  reg_first;
      logic [3:0]  reg_second;
      logic [3:0]  reg_third;
      logic        operand_is_const;
      logic        has_offset;
      logic [31:0] const_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic        two_words;
      logic        error;
   } enc_result_type;

   localparam logic [31:0] NOP_WORD      = 32'he1a00000;
   localparam logic [31:0] LDR_BASE      = 32'he5100000;
   localparam logic [31:0] LDRB_BASE     = 32'he5500000;
   localparam logic [31:0] LDRSB_BASE    = 32'he15000d0;
   localparam logic [31:0] LDRH_BASE     = 32'he15000b0;
   localparam logic [31:0] LDRSH_BASE    = 32'he15000f0;
   localparam logic [31:0] STR_BASE      = 32'he5000000;
   localparam logic [31:0] STRB_BASE     = 32'he5400000;
   localparam logic [31:0] STRH_BASE     = 32'he14000b0;
   localparam logic [31:0] MOVW_BASE     = 32'he3000000;
   localparam logic [31:0] MOVT_BASE     = 32'he3400000;
   localparam logic [31:0] ALU_IMM_BASE  = 32'he2000000;
   localparam logic [31:0] ALU_REG_BASE  = 32'he0000000;
   localparam logic [31:0] OP_ADD        = 32'h00800000;
   localparam logic [31:0] OP_SUB        = 32'h00400000;
   localparam logic [31:0] OP_AND        = 32'h00000000;
   localparam logic [31:0] OP_ORR        = 32'h01800000;
   localparam logic [31:0] OP_EOR        = 32'h00200000;
   localparam logic [31:0] SH_LSL        = 32'he1a00000;
   localparam logic [31:0] SH_LSR        = 32'he1a00020;
   localparam logic [31:0] SH_ASR        = 32'he1a00040;
   localparam logic [31:0] SH_ROR        = 32'he1a00060;
   localparam logic [31:0] CMP_IMM_BASE  = 32'he3500000;
   localparam logic [31:0] CMP_REG_BASE  = 32'he1500000;
   localparam logic [31:0] MVN_BASE      = 32'he1e00000;
   localparam logic [31:0] MOV_COND_BASE = 32'h01a00000;
   localparam logic [31:0] B_ALWAYS      = 32'hea000000;
   localparam logic [31:0] MOV_PC_BASE   = 32'he1a0f000;
   localparam logic [31:0] B_COND_BASE   = 32'h0a000000;
   localparam logic [31:0] UDIV_BASE     = 32'he730f010;
   localparam logic [31:0] SDIV_BASE     = 32'he710f010;
   localparam logic [31:0] MUL_BASE      = 32'he0000090;
   localparam logic [31:0] SWI_BASE      = 32'hef000000;
   localparam logic [31:0] BKPT_WORD     = 32'he1200070;

   localparam logic [3:0] COND_EQ = 4'h0;
   localparam logic [3:0] COND_NE = 4'h1;
   localparam logic [3:0] COND_HS = 4'h2;
   localparam logic [3:0] COND_LO = 4'h3;
   localparam logic [3:0] COND_HI = 4'h8;
   localparam logic [3:0] COND_LS = 4'h9;
   localparam logic [3:0] COND_GE = 4'ha;
   localparam logic [3:0] COND_LT = 4'hb;
   localparam logic [3:0] COND_GT = 4'hc;
   localparam logic [3:0] COND_LE = 4'hd;

endpackage
`default_nettype wire

### rtl/core/a32enc_if.sv
// Valid/ready channel interfaces for request and response items of the encoder.
`default_nettype none
interface a32enc_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  req_type;
   logic [3:0]  reg_first;
   logic [3:0]  reg_second;
   logic [3:0]  reg_third;
   logic        operand_is_const;
   logic        has_offset;
   logic [31:0] const_value;

   modport source (output valid, req_type, reg_first, reg_second, reg_third,
                   operand_is_const, has_offset, const_value, input ready);
   modport sink   (input valid, req_type, reg_first, reg_second, reg_third,
                   operand_is_const, has_offset, const_value, output ready);
endinterface

interface a32enc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] machine_word;
   logic        last_word;
   logic        encode_error;

   modport source (output valid, machine_word, last_word, encode_error, input ready);
   modport sink   (input valid, machine_word, last_word, encode_error, output ready);
endinterface
`default_nettype wire

### rtl/core/arm32_instruction_encoder.sv
// Top level of the A32 instruction encoder: input register, encoder and result register.
// Usage:
//  - req_if carries one generic operation per item (kind, three register
//    numbers, constant and offset flags, 32-bit constant); taken when
//    valid and ready are both high at a rising clock edge.
//  - rsp_if carries one A32 word per item with last_word and encode_error.
//    Most kinds give one word; a constant move (movw, movt) and the select
//    kinds (two conditional movs) give two, the first with last_word low.
//  - An accepted item passes from the input register through the encoder
//    into the result register; the second word (if any) shows right after
//    the edge at which the first word is taken.
//  - Throughput: one item per cycle for single-word kinds while the
//    receiver does not stall; two-word kinds hold the result register
//    for both of their words.
//  - Rejected encodings give one NOP word with encode_error high.
//  - When the receiver stalls, the result register holds, the input
//    register still takes one more item, and req_if.ready then drops.
//  - Synchronous reset empties all stages; nothing is in flight after it.
`default_nettype none
module arm32_instruction_encoder (
   input wire logic    clock,
   input wire logic    reset,
   a32enc_req_if.sink  req_if,
   a32enc_rsp_if.source rsp_if
);

   // input register
   logic                      in_valid_ff, in_valid_in;
   a32enc_pkg::req_item_type  in_item_ff, in_item_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_last_ff, out_last_in;
   logic        out_err_ff, out_err_in;

   // pending second word of a two-word item
   logic        sec_valid_ff, sec_valid_in;
   logic [31:0] sec_word_ff, sec_word_in;

   a32enc_pkg::enc_result_type enc;

   logic out_load, take_sec, take_in, req_fire;

   a32enc_core u_core (
      .item   (in_item_ff),
      .result (enc)
   );

   // result register can be refilled when empty or being drained
   assign out_load = !out_valid_ff || rsp_if.ready;
   // the pending second word goes out before any new item
   assign take_sec = out_load && sec_valid_ff;
   assign take_in  = out_load && !sec_valid_ff && in_valid_ff;

   assign req_if.ready = !in_valid_ff || take_in;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in                 = 1'b1;
         in_item_in.req_type         = req_if.req_type;
         in_item_in.reg_first        = req_if.reg_first;
         in_item_in.reg_second       = req_if.reg_second;
         in_item_in.reg_third        = req_if.reg_third;
         in_item_in.operand_is_const = req_if.operand_is_const;
         in_item_in.has_offset       = req_if.has_offset;
         in_item_in.const_value      = req_if.const_value;
      end else if (take_in) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      sec_valid_in = sec_valid_ff;
      sec_word_in  = sec_word_ff;
      if (take_sec) begin
         out_valid_in = 1'b1;
         out_word_in  = sec_word_ff;
         out_last_in  = 1'b1;
         out_err_in   = 1'b0;
         sec_valid_in = 1'b0;
      end else if (take_in) begin
         out_valid_in = 1'b1;
         out_word_in  = enc.word0;
         out_last_in  = !enc.two_words;
         out_err_in   = enc.error;
         sec_valid_in = enc.two_words;
         sec_word_in  = enc.word1;
      end else if (out_load) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         sec_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         sec_valid_ff <= sec_valid_in;
      end
      in_item_ff  <= in_item_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
      out_err_ff  <= out_err_in;
      sec_word_ff <= sec_word_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.machine_word = out_word_ff;
   assign rsp_if.last_word    = out_last_ff;
   assign rsp_if.encode_error = out_err_ff;

endmodule
`default_nettype wire

### rtl/core/a32enc_rotimm.sv
// Rotated 8-bit immediate search: smallest even rotation that forms the value.
`default_nettype none
module a32enc_rotimm (
   input  wire logic [31:0] value,
   output logic             fits,
   output logic [11:0]      enc
);

   always_comb begin
      logic [63:0] dbl;
      logic [31:0] rot;
      fits = 1'b0;
      enc  = '0;
      dbl  = {value, value};
      // descending, so the smallest fitting rotation wins
      for (int r = 15; r >= 0; r--) begin
         rot = 32'((dbl << (2 * r)) >> 32);
         if (rot[31:8] == 24'd0) begin
            fits = 1'b1;
            enc  = {4'(r), rot[7:0]};
         end
      end
   end

endmodule
`default_nettype wire

### rtl/core/a32enc_core.sv
// Combinational encoder: one request item to one or two A32 words and an error flag.
`default_nettype none
module a32enc_core (
   input  wire a32enc_pkg::req_item_type   item,
   output a32enc_pkg::enc_result_type      result
);

   logic        imm_fits;
   logic [11:0] imm_enc;

   a32enc_rotimm u_rotimm (
      .value (item.const_value),
      .fits  (imm_fits),
      .enc   (imm_enc)
   );

   always_comb begin
      logic [31:0] ra_d, rb_d, rc_d, ra_n, rb_n, rc_s;
      logic [31:0] cv;
      logic [7:0]  mag;
      logic        up;
      logic        off_ok;
      logic [31:0] neg;
      logic [31:0] lo_hi;
      logic [31:0] mem_base;
      logic [31:0] alu_op;
      logic [31:0] sh_op;
      logic [4:0]  sh_amt;
      logic [3:0]  cond0, cond1;
      logic [31:0] swi_num;
      logic [31:0] w0, w1;
      logic        two, err;

      cv   = item.const_value;
      ra_d = 32'(item.reg_first) << 12;
      rb_d = 32'(item.reg_second) << 12;
      ra_n = 32'(item.reg_first) << 16;
      rb_n = 32'(item.reg_second) << 16;
      rc_s = 32'(item.reg_third) << 8;
      rc_d = 32'(item.reg_third);

      // offset split into magnitude and U bit
      neg = 32'd0 - cv;
      if (!item.has_offset) begin
         mag = 8'd0; up = 1'b1; off_ok = 1'b1;
      end else if (cv <= 32'd255) begin
         mag = cv[7:0]; up = 1'b1; off_ok = 1'b1;
      end else if (cv >= 32'hffffff01) begin
         mag = neg[7:0]; up = 1'b0; off_ok = 1'b1;
      end else begin
         mag = 8'd0; up = 1'b1; off_ok = 1'b0;
      end
      lo_hi = {20'd0, mag[7:4], 4'd0, mag[3:0]};

      mem_base = a32enc_pkg::LDR_BASE;
      alu_op   = a32enc_pkg::OP_ADD;
      sh_op    = a32enc_pkg::SH_LSL;
      cond0    = a32enc_pkg::COND_EQ;
      cond1    = a32enc_pkg::COND_NE;
      sh_amt   = cv[4:0];
      swi_num  = item.has_offset ? cv : 32'd0;
      w0  = a32enc_pkg::NOP_WORD;
      w1  = 32'd0;
      two = 1'b0;
      err = 1'b0;

      unique case (a32enc_pkg::kind_type'(item.req_type))
         a32enc_pkg::KIND_LOAD, a32enc_pkg::KIND_LOAD8: begin
            mem_base = (item.req_type == a32enc_pkg::KIND_LOAD) ?
                       a32enc_pkg::LDR_BASE : a32enc_pkg::LDRB_BASE;
            w0  = mem_base | 32'(mag) | (32'(up) << 23) | ra_d | rb_n;
            err = !off_ok;
         end
         a32enc_pkg::KIND_LOADS8, a32enc_pkg::KIND_LOAD16, a32enc_pkg::KIND_LOADS16: begin
            priority if (item.req_type == a32enc_pkg::KIND_LOADS8)
               mem_base = a32enc_pkg::LDRSB_BASE;
            else if (item.req_type == a32enc_pkg::KIND_LOAD16)
               mem_base = a32enc_pkg::LDRH_BASE;
            else
               mem_base = a32enc_pkg::LDRSH_BASE;
            w0  = mem_base | lo_hi | (32'(up) << 23) | ra_d | rb_n;
            err = !off_ok;
         end
         a32enc_pkg::KIND_STORE, a32enc_pkg::KIND_STORE8: begin
            mem_base = (item.req_type == a32enc_pkg::KIND_STORE) ?
                       a32enc_pkg::STR_BASE : a32enc_pkg::STRB_BASE;
            w0  = mem_base | 32'(mag) | (32'(up) << 23) | rb_d | ra_n;
            err = !off_ok;
         end
         a32enc_pkg::KIND_STORE16: begin
            w0  = a32enc_pkg::STRH_BASE | lo_hi | (32'(up) << 23) | rb_d | ra_n;
            err = !off_ok;
         end
         a32enc_pkg::KIND_MOVE: begin
            if (item.operand_is_const) begin
               w0  = a32enc_pkg::MOVW_BASE | {12'd0, cv[15:12], 4'd0, cv[11:0]} | ra_d;
               w1  = a32enc_pkg::MOVT_BASE | {12'd0, cv[31:28], 4'd0, cv[27:16]} | ra_d;
               two = 1'b1;
            end else begin
               w0 = a32enc_pkg::NOP_WORD | 32'(item.reg_second) | ra_d;
            end
         end
         a32enc_pkg::KIND_ADD, a32enc_pkg::KIND_SUB, a32enc_pkg::KIND_AND,
         a32enc_pkg::KIND_OR, a32enc_pkg::KIND_XOR: begin
            priority if (item.req_type == a32enc_pkg::KIND_ADD) alu_op = a32enc_pkg::OP_ADD;
            else if (item.req_type == a32enc_pkg::KIND_SUB)     alu_op = a32enc_pkg::OP_SUB;
            else if (item.req_type == a32enc_pkg::KIND_AND)     alu_op = a32enc_pkg::OP_AND;
            else if (item.req_type == a32enc_pkg::KIND_OR)      alu_op = a32enc_pkg::OP_ORR;
            else                                                 alu_op = a32enc_pkg::OP_EOR;
            if (item.operand_is_const) begin
               w0  = a32enc_pkg::ALU_IMM_BASE | alu_op | ra_d | rb_n | 32'(imm_enc);
               err = !imm_fits;
            end else begin
               w0 = a32enc_pkg::ALU_REG_BASE | alu_op | ra_d | rb_n | rc_d;
            end
         end
         a32enc_pkg::KIND_SHL, a32enc_pkg::KIND_SHR, a32enc_pkg::KIND_SAR,
         a32enc_pkg::KIND_ROL, a32enc_pkg::KIND_ROR: begin
            priority if (item.req_type == a32enc_pkg::KIND_SHL) sh_op = a32enc_pkg::SH_LSL;
            else if (item.req_type == a32enc_pkg::KIND_SHR)     sh_op = a32enc_pkg::SH_LSR;
            else if (item.req_type == a32enc_pkg::KIND_SAR)     sh_op = a32enc_pkg::SH_ASR;
            else                                                 sh_op = a32enc_pkg::SH_ROR;
            // rotate left by n is rotate right by 32-n
            if (item.req_type == a32enc_pkg::KIND_ROL)
               sh_amt = 5'd0 - cv[4:0];
            if (item.operand_is_const) begin
               w0  = sh_op | ra_d | 32'(item.reg_second) | (32'(sh_amt) << 7);
               err = (cv[31:5] != 27'd0) || (cv[4:0] == 5'd0);
            end else begin
               w0 = sh_op | ra_d | 32'(item.reg_second) | 32'h10 | rc_s;
            end
         end
         a32enc_pkg::KIND_CMP: begin
            if (item.operand_is_const) begin
               w0  = a32enc_pkg::CMP_IMM_BASE | ra_n | 32'(imm_enc);
               err = !imm_fits;
            end else begin
               w0 = a32enc_pkg::CMP_REG_BASE | ra_n | 32'(item.reg_second);
            end
         end
         a32enc_pkg::KIND_NOT: begin
            w0 = a32enc_pkg::MVN_BASE | ra_d | 32'(item.reg_second);
         end
         a32enc_pkg::KIND_SELEQ, a32enc_pkg::KIND_SELGE, a32enc_pkg::KIND_SELGT,
         a32enc_pkg::KIND_SELGES, a32enc_pkg::KIND_SELGTS: begin
            priority if (item.req_type == a32enc_pkg::KIND_SELEQ) begin
               cond0 = a32enc_pkg::COND_EQ; cond1 = a32enc_pkg::COND_NE;
            end else if (item.req_type == a32enc_pkg::KIND_SELGE) begin
               cond0 = a32enc_pkg::COND_HS; cond1 = a32enc_pkg::COND_LO;
            end else if (item.req_type == a32enc_pkg::KIND_SELGT) begin
               cond0 = a32enc_pkg::COND_HI; cond1 = a32enc_pkg::COND_LS;
            end else if (item.req_type == a32enc_pkg::KIND_SELGES) begin
               cond0 = a32enc_pkg::COND_GE; cond1 = a32enc_pkg::COND_LT;
            end else begin
               cond0 = a32enc_pkg::COND_GT; cond1 = a32enc_pkg::COND_LE;
            end
            w0  = {cond0, 28'd0} | a32enc_pkg::MOV_COND_BASE | 32'(item.reg_second) | ra_d;
            w1  = {cond1, 28'd0} | a32enc_pkg::MOV_COND_BASE | rc_d | ra_d;
            two = 1'b1;
         end
         a32enc_pkg::KIND_BRA: begin
            w0 = item.operand_is_const ? a32enc_pkg::B_ALWAYS :
                 (a32enc_pkg::MOV_PC_BASE | 32'(item.reg_first));
         end
         a32enc_pkg::KIND_BNE, a32enc_pkg::KIND_BEQ, a32enc_pkg::KIND_BG,
         a32enc_pkg::KIND_BLE, a32enc_pkg::KIND_BL, a32enc_pkg::KIND_BGE: begin
            priority if (item.req_type == a32enc_pkg::KIND_BNE) cond0 = a32enc_pkg::COND_NE;
            else if (item.req_type == a32enc_pkg::KIND_BEQ)     cond0 = a32enc_pkg::COND_EQ;
            else if (item.req_type == a32enc_pkg::KIND_BG)      cond0 = a32enc_pkg::COND_HI;
            else if (item.req_type == a32enc_pkg::KIND_BLE)     cond0 = a32enc_pkg::COND_LS;
            else if (item.req_type == a32enc_pkg::KIND_BL)      cond0 = a32enc_pkg::COND_LO;
            else                                                 cond0 = a32enc_pkg::COND_HS;
            w0 = {cond0, 28'd0} | a32enc_pkg::B_COND_BASE;
         end
         a32enc_pkg::KIND_DIV: begin
            w0 = a32enc_pkg::UDIV_BASE | ra_n | 32'(item.reg_second) | rc_s;
         end
         a32enc_pkg::KIND_DIVS: begin
            w0 = a32enc_pkg::SDIV_BASE | ra_n | 32'(item.reg_second) | rc_s;
         end
         a32enc_pkg::KIND_MUL: begin
            w0 = a32enc_pkg::MUL_BASE | ra_n | 32'(item.reg_second) | rc_s;
         end
         a32enc_pkg::KIND_SWI: begin
            w0  = a32enc_pkg::SWI_BASE | swi_num;
            err = (swi_num[31:24] != 8'd0);
         end
         a32enc_pkg::KIND_BKPT: begin
            w0 = a32enc_pkg::BKPT_WORD;
         end
         default: begin
            err = 1'b1;
         end
      endcase

      if (err) begin
         w0  = a32enc_pkg::NOP_WORD;
         two = 1'b0;
      end

      result.word0     = w0;
      result.word1     = w1;
      result.two_words = two;
      result.error     = err;
   end

endmodule
`default_nettype wire

### rtl/core/a32enc_checker.sv
// Port-level assertion checker for the A32 encoder, with its bind statement.
`default_nettype none
`include "assert_macros.svh"
module a32enc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_word,
   input wire logic        rsp_last,
   input wire logic        rsp_error
);

   logic rsp_fire;
   logic err_word_ok;
   logic second_word_ok;
   assign rsp_fire       = rsp_valid && rsp_ready;
   // a rejected item is a single NOP word
   assign err_word_ok    = rsp_last && (rsp_word == a32enc_pkg::NOP_WORD);
   assign second_word_ok = rsp_valid && rsp_last && !rsp_error;

   `A32_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `A32_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `A32_ASSERT_IMPLY(a_err_is_nop, clock, reset, rsp_valid && rsp_error, err_word_ok)
   `A32_ASSERT_NEXT(a_second_word, clock, reset, rsp_fire && !rsp_last, second_word_ok)

endmodule

bind arm32_instruction_encoder a32enc_checker u_a32enc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_word  (rsp_if.machine_word),
   .rsp_last  (rsp_if.last_word),
   .rsp_error (rsp_if.encode_error)
);
`default_nettype wire

### bench/arm32_instruction_encoder_tb.sv
// Self-checking testbench of the A32 instruction encoder: directed table, then random items.
module arm32_instruction_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One encoded word as it should appear on the response channel.
   typedef struct packed {
      logic [31:0] word;
      logic        last;
      logic        error;
   } exp_word_type;

   // Directed row: the item, and a hand-written expectation where one is obvious.
   typedef struct packed {
      a32enc_pkg::req_item_type op;
      logic                     fixed_exp;
      logic [31:0]              word;
      logic                     error;
   } directed_row_type;

   // Highest kind number; everything above KIND_BKPT up to here is unsupported.
   localparam logic [5:0]  KIND_TOP       = 6'd63;
   // Bit 4 of a data-processing word selects a register-held shift amount.
   localparam logic [31:0] SHIFT_BY_REG   = 32'h00000010;
   localparam logic [31:0] NOP            = a32enc_pkg::NOP_WORD;
   localparam int          RANDOM_ITEMS   = 500;
   localparam int          QUIET_FIRST    = 150;
   localparam int          QUIET_LAST     = 299;
   localparam int          MAX_REPORTS    = 100;

   logic clock = 1'b0;
   logic reset;

   a32enc_req_if req_ch();
   a32enc_rsp_if rsp_ch();

   arm32_instruction_encoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   exp_word_type expected_words [$];
   int           mismatch_count = 0;
   // Random idling on both sides; cleared for a quiet stretch of the random part.
   bit           idle_enable = 1'b1;

   // Directed items. Rows with fixed_exp set carry a single word read straight
   // off the encoding rules: extremes, error cases, fixed opcodes.
   directed_row_type directed_rows [30] = '{
      // load at the largest positive offset, all registers r15
      '{'{a32enc_pkg::KIND_LOAD, 4'd15, 4'd15, 4'd0, 1'b0, 1'b1, 32'd255},
        1'b1, 32'he59ff0ff, 1'b0},
      // byte load at the most negative offset: U bit clear
      '{'{a32enc_pkg::KIND_LOAD8, 4'd1, 4'd2, 4'd0, 1'b0, 1'b1, 32'hffffff01},
        1'b0, 32'h0, 1'b0},
      // one past the negative end
      '{'{a32enc_pkg::KIND_LOADS8, 4'd3, 4'd4, 4'd0, 1'b0, 1'b1, 32'hffffff00},
        1'b1, NOP, 1'b1},
      // no offset flag: constant ignored
      '{'{a32enc_pkg::KIND_LOAD16, 4'd5, 4'd6, 4'd0, 1'b0, 1'b0, 32'hffffffff},
        1'b0, 32'h0, 1'b0},
      // one past the positive end
      '{'{a32enc_pkg::KIND_LOADS16, 4'd7, 4'd8, 4'd0, 1'b0, 1'b1, 32'd256},
        1'b1, NOP, 1'b1},
      '{'{a32enc_pkg::KIND_STORE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1, 32'd0},
        1'b1, 32'he5800000, 1'b0},
      '{'{a32enc_pkg::KIND_STORE8, 4'd9, 4'd10, 4'd0, 1'b0, 1'b1, 32'hffffff9c},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_STORE16, 4'd14, 4'd13, 4'd0, 1'b0, 1'b1, 32'h000000a5},
        1'b0, 32'h0, 1'b0},
      // movw/movt pair, all ones
      '{'{a32enc_pkg::KIND_MOVE, 4'd15, 4'd0, 4'd0, 1'b1, 1'b0, 32'hffffffff},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_MOVE, 4'd0, 4'd15, 4'd0, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      // byte in the top of the word: needs a rotation
      '{'{a32enc_pkg::KIND_ADD, 4'd1, 4'd2, 4'd0, 1'b1, 1'b0, 32'hff000000},
        1'b0, 32'h0, 1'b0},
      // nine significant bits: no rotation fits
      '{'{a32enc_pkg::KIND_SUB, 4'd3, 4'd4, 4'd0, 1'b1, 1'b0, 32'h00000101},
        1'b1, NOP, 1'b1},
      '{'{a32enc_pkg::KIND_AND, 4'd5, 4'd6, 4'd7, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_OR, 4'd8, 4'd9, 4'd0, 1'b1, 1'b0, 32'h000003fc},
        1'b0, 32'h0, 1'b0},
      // byte split across bit 31 and bit 0
      '{'{a32enc_pkg::KIND_XOR, 4'd10, 4'd11, 4'd0, 1'b1, 1'b0, 32'hf000000f},
        1'b0, 32'h0, 1'b0},
      // constant shift of zero and of 32 are rejected
      '{'{a32enc_pkg::KIND_SHL, 4'd1, 4'd2, 4'd0, 1'b1, 1'b0, 32'd0},
        1'b1, NOP, 1'b1},
      '{'{a32enc_pkg::KIND_SHR, 4'd1, 4'd2, 4'd0, 1'b1, 1'b0, 32'd32},
        1'b1, NOP, 1'b1},
      '{'{a32enc_pkg::KIND_SAR, 4'd3, 4'd4, 4'd0, 1'b1, 1'b0, 32'd31},
        1'b0, 32'h0, 1'b0},
      // rotate left by one becomes ror #31
      '{'{a32enc_pkg::KIND_ROL, 4'd5, 4'd6, 4'd0, 1'b1, 1'b0, 32'd1},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_ROR, 4'd7, 4'd8, 4'd9, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_CMP, 4'd15, 4'd0, 4'd0, 1'b1, 1'b0, 32'd0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_NOT, 4'd12, 4'd13, 4'd0, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_SELEQ, 4'd1, 4'd2, 4'd3, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_SELGTS, 4'd4, 4'd5, 4'd6, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_BRA, 4'd0, 4'd0, 4'd0, 1'b1, 1'b0, 32'h0},
        1'b1, 32'hea000000, 1'b0},
      '{'{a32enc_pkg::KIND_BLE, 4'd0, 4'd0, 4'd0, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_MUL, 4'd15, 4'd15, 4'd15, 1'b0, 1'b0, 32'h0},
        1'b0, 32'h0, 1'b0},
      // largest and one-too-large interrupt numbers
      '{'{a32enc_pkg::KIND_SWI, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1, 32'h00ffffff},
        1'b0, 32'h0, 1'b0},
      '{'{a32enc_pkg::KIND_SWI, 4'd0, 4'd0, 4'd0, 1'b0, 1'b1, 32'h01000000},
        1'b1, NOP, 1'b1},
      '{'{KIND_TOP, 4'd15, 4'd15, 4'd15, 1'b1, 1'b1, 32'hffffffff},
        1'b1, NOP, 1'b1}
   };

   // Immediate operand: smallest even rotation that brings v into 8 bits.
   function automatic logic fit_rotated_imm(input logic [31:0] v, output logic [11:0] enc);
      logic [63:0] twice;
      logic [31:0] t;
      twice = {v, v};
      enc = '0;
      for (int r = 0; r < 16; r++) begin
         t = twice[63 - 2*r -: 32];   // v rotated left by 2r
         if (t <= 32'h000000ff) begin
            enc = {4'(r), t[7:0]};
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Memory offset: magnitude and U bit, or 0 when outside -255..255.
   function automatic logic split_offset(input logic [31:0] v, output logic [7:0] mag,
                                         output logic up);
      mag = '0;
      up  = 1'b1;
      if (v <= 32'd255) begin
         mag = v[7:0];
         return 1'b1;
      end
      if (v >= 32'hffffff01) begin
         mag = 8'(32'd0 - v);
         up  = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the words the encoder must emit for one operation and queues them.
   function automatic void predict_a32_words(input a32enc_pkg::req_item_type op);
      logic [31:0] ra, rb, rc, cv, w0, w1, base, lo_hi, rt, rn, sh, amt, num, alu;
      logic [11:0] enc;
      logic [7:0]  mag;
      logic [3:0]  c0, c1;
      logic        up, ok, two, bad;
      ra    = {28'd0, op.reg_first};
      rb    = {28'd0, op.reg_second};
      rc    = {28'd0, op.reg_third};
      cv    = op.const_value;
      w0    = a32enc_pkg::NOP_WORD;
      w1    = '0;
      two   = 1'b0;
      bad   = 1'b0;
      mag   = '0;
      up    = 1'b1;
      enc   = '0;
      ok    = 1'b1;
      base  = '0;
      alu   = '0;
      sh    = '0;
      c0    = '0;
      c1    = '0;
      if (op.req_type > a32enc_pkg::KIND_BKPT) begin
         bad = 1'b1;
      end else begin
         case (op.req_type)
            a32enc_pkg::KIND_LOAD, a32enc_pkg::KIND_LOAD8, a32enc_pkg::KIND_LOADS8,
            a32enc_pkg::KIND_LOAD16, a32enc_pkg::KIND_LOADS16, a32enc_pkg::KIND_STORE,
            a32enc_pkg::KIND_STORE8, a32enc_pkg::KIND_STORE16: begin
               if (op.has_offset) ok = split_offset(cv, mag, up);
               if (!ok) begin
                  bad = 1'b1;
               end else begin
                  lo_hi = {20'd0, mag[7:4], 4'd0, mag[3:0]};
                  // loads: Rt is the destination; stores: Rn is the first register
                  if (op.req_type <= a32enc_pkg::KIND_LOADS16) begin
                     rt = ra;
                     rn = rb;
                  end else begin
                     rt = rb;
                     rn = ra;
                  end
                  case (op.req_type)
                     a32enc_pkg::KIND_LOAD:    base = a32enc_pkg::LDR_BASE   | {24'd0, mag};
                     a32enc_pkg::KIND_LOAD8:   base = a32enc_pkg::LDRB_BASE  | {24'd0, mag};
                     a32enc_pkg::KIND_LOADS8:  base = a32enc_pkg::LDRSB_BASE | lo_hi;
                     a32enc_pkg::KIND_LOAD16:  base = a32enc_pkg::LDRH_BASE  | lo_hi;
                     a32enc_pkg::KIND_LOADS16: base = a32enc_pkg::LDRSH_BASE | lo_hi;
                     a32enc_pkg::KIND_STORE:   base = a32enc_pkg::STR_BASE   | {24'd0, mag};
                     a32enc_pkg::KIND_STORE8:  base = a32enc_pkg::STRB_BASE  | {24'd0, mag};
                     default:                  base = a32enc_pkg::STRH_BASE  | lo_hi;
                  endcase
                  w0 = base | ({31'd0, up} << 23) | (rt << 12) | (rn << 16);
               end
            end
            a32enc_pkg::KIND_MOVE: begin
               if (op.operand_is_const) begin
                  w0  = a32enc_pkg::MOVW_BASE | {20'd0, cv[11:0]}
                        | ({28'd0, cv[15:12]} << 16) | (ra << 12);
                  w1  = a32enc_pkg::MOVT_BASE | {20'd0, cv[27:16]}
                        | ({28'd0, cv[31:28]} << 16) | (ra << 12);
                  two = 1'b1;
               end else begin
                  w0 = a32enc_pkg::NOP_WORD | rb | (ra << 12);
               end
            end
            a32enc_pkg::KIND_ADD, a32enc_pkg::KIND_SUB, a32enc_pkg::KIND_AND,
            a32enc_pkg::KIND_OR, a32enc_pkg::KIND_XOR: begin
               case (op.req_type)
                  a32enc_pkg::KIND_ADD: alu = a32enc_pkg::OP_ADD;
                  a32enc_pkg::KIND_SUB: alu = a32enc_pkg::OP_SUB;
                  a32enc_pkg::KIND_AND: alu = a32enc_pkg::OP_AND;
                  a32enc_pkg::KIND_OR:  alu = a32enc_pkg::OP_ORR;
                  default:              alu = a32enc_pkg::OP_EOR;
               endcase
               if (op.operand_is_const) begin
                  ok = fit_rotated_imm(cv, enc);
                  if (ok) w0 = a32enc_pkg::ALU_IMM_BASE | alu | (ra << 12) | (rb << 16)
                               | {20'd0, enc};
                  else    bad = 1'b1;
               end else begin
                  w0 = a32enc_pkg::ALU_REG_BASE | alu | (ra << 12) | (rb << 16) | rc;
               end
            end
            a32enc_pkg::KIND_SHL, a32enc_pkg::KIND_SHR, a32enc_pkg::KIND_SAR,
            a32enc_pkg::KIND_ROL, a32enc_pkg::KIND_ROR: begin
               case (op.req_type)
                  a32enc_pkg::KIND_SHL: sh = a32enc_pkg::SH_LSL;
                  a32enc_pkg::KIND_SHR: sh = a32enc_pkg::SH_LSR;
                  a32enc_pkg::KIND_SAR: sh = a32enc_pkg::SH_ASR;
                  default:              sh = a32enc_pkg::SH_ROR;   // rotate left goes out as ror
               endcase
               sh = sh | (ra << 12) | rb;
               if (op.operand_is_const) begin
                  if (cv < 32'd1 || cv > 32'd31) begin
                     bad = 1'b1;
                  end else begin
                     amt = (op.req_type == a32enc_pkg::KIND_ROL) ? 32'd32 - cv : cv;
                     w0  = sh | (amt << 7);
                  end
               end else begin
                  w0 = sh | SHIFT_BY_REG | (rc << 8);
               end
            end
            a32enc_pkg::KIND_CMP: begin
               if (op.operand_is_const) begin
                  ok = fit_rotated_imm(cv, enc);
                  if (ok) w0 = a32enc_pkg::CMP_IMM_BASE | (ra << 16) | {20'd0, enc};
                  else    bad = 1'b1;
               end else begin
                  w0 = a32enc_pkg::CMP_REG_BASE | (ra << 16) | rb;
               end
            end
            a32enc_pkg::KIND_NOT: w0 = a32enc_pkg::MVN_BASE | (ra << 12) | rb;
            a32enc_pkg::KIND_SELEQ, a32enc_pkg::KIND_SELGE, a32enc_pkg::KIND_SELGT,
            a32enc_pkg::KIND_SELGES, a32enc_pkg::KIND_SELGTS: begin
               case (op.req_type)
                  a32enc_pkg::KIND_SELEQ: begin
                     c0 = a32enc_pkg::COND_EQ; c1 = a32enc_pkg::COND_NE;
                  end
                  a32enc_pkg::KIND_SELGE: begin
                     c0 = a32enc_pkg::COND_HS; c1 = a32enc_pkg::COND_LO;
                  end
                  a32enc_pkg::KIND_SELGT: begin
                     c0 = a32enc_pkg::COND_HI; c1 = a32enc_pkg::COND_LS;
                  end
                  a32enc_pkg::KIND_SELGES: begin
                     c0 = a32enc_pkg::COND_GE; c1 = a32enc_pkg::COND_LT;
                  end
                  default: begin
                     c0 = a32enc_pkg::COND_GT; c1 = a32enc_pkg::COND_LE;
                  end
               endcase
               w0  = {c0, 28'd0} | a32enc_pkg::MOV_COND_BASE | rb | (ra << 12);
               w1  = {c1, 28'd0} | a32enc_pkg::MOV_COND_BASE | rc | (ra << 12);
               two = 1'b1;
            end
            a32enc_pkg::KIND_BRA: begin
               w0 = op.operand_is_const ? a32enc_pkg::B_ALWAYS
                                        : (a32enc_pkg::MOV_PC_BASE | ra);
            end
            a32enc_pkg::KIND_BNE, a32enc_pkg::KIND_BEQ, a32enc_pkg::KIND_BG,
            a32enc_pkg::KIND_BLE, a32enc_pkg::KIND_BL, a32enc_pkg::KIND_BGE: begin
               case (op.req_type)
                  a32enc_pkg::KIND_BNE: c0 = a32enc_pkg::COND_NE;
                  a32enc_pkg::KIND_BEQ: c0 = a32enc_pkg::COND_EQ;
                  a32enc_pkg::KIND_BG:  c0 = a32enc_pkg::COND_HI;
                  a32enc_pkg::KIND_BLE: c0 = a32enc_pkg::COND_LS;
                  a32enc_pkg::KIND_BL:  c0 = a32enc_pkg::COND_LO;
                  default:              c0 = a32enc_pkg::COND_HS;
               endcase
               w0 = {c0, 28'd0} | a32enc_pkg::B_COND_BASE;   // offset field stays zero
            end
            a32enc_pkg::KIND_DIV:  w0 = a32enc_pkg::UDIV_BASE | (ra << 16) | rb | (rc << 8);
            a32enc_pkg::KIND_DIVS: w0 = a32enc_pkg::SDIV_BASE | (ra << 16) | rb | (rc << 8);
            a32enc_pkg::KIND_MUL:  w0 = a32enc_pkg::MUL_BASE  | (ra << 16) | rb | (rc << 8);
            a32enc_pkg::KIND_SWI: begin
               num = op.has_offset ? cv : 32'd0;
               if (num > 32'h00ffffff) bad = 1'b1;
               else                    w0 = a32enc_pkg::SWI_BASE | num;
            end
            default: w0 = a32enc_pkg::BKPT_WORD;
         endcase
      end
      if (bad) begin
         w0  = a32enc_pkg::NOP_WORD;
         two = 1'b0;
      end
      expected_words.push_back('{w0, !two, bad});
      if (two) expected_words.push_back('{w1, 1'b1, 1'b0});
   endfunction

   // Random operation; constants are steered so most items get past the range checks.
   function automatic a32enc_pkg::req_item_type random_operation();
      a32enc_pkg::req_item_type op;
      logic [31:0]  x;
      int unsigned  pick;
      int unsigned  s;
      if ($urandom_range(99) < 8)
         op.req_type = 6'($urandom_range(KIND_TOP, a32enc_pkg::KIND_BKPT + 1));
      else
         op.req_type = 6'($urandom_range(a32enc_pkg::KIND_BKPT));
      op.reg_first        = 4'($urandom);
      op.reg_second       = 4'($urandom);
      op.reg_third        = 4'($urandom);
      op.operand_is_const = 1'($urandom);
      op.has_offset       = 1'($urandom);
      pick = $urandom_range(9);
      op.const_value = $urandom;
      if (op.req_type <= a32enc_pkg::KIND_STORE16) begin
         if (pick < 4)      op.const_value = $urandom_range(255);
         else if (pick < 8) op.const_value = 32'd0 - $urandom_range(255, 1);
         else if (pick < 9) op.const_value = ($urandom_range(1) != 0) ? 32'd256 : 32'hffffff00;
      end else if ((op.req_type >= a32enc_pkg::KIND_ADD && op.req_type <= a32enc_pkg::KIND_XOR)
                   || op.req_type == a32enc_pkg::KIND_CMP) begin
         if (pick < 6) begin
            // a byte rotated right by an even amount always encodes
            x = {24'd0, 8'($urandom)};
            s = 2 * $urandom_range(15);
            op.const_value = 32'({x, x} >> s);
         end else if (pick < 8) begin
            op.const_value = $urandom_range(255);
         end
      end else if (op.req_type >= a32enc_pkg::KIND_SHL && op.req_type <= a32enc_pkg::KIND_ROR) begin
         if (pick < 7)      op.const_value = $urandom_range(31, 1);
         else if (pick < 9) op.const_value = $urandom_range(32);
      end else if (op.req_type == a32enc_pkg::KIND_SWI) begin
         if (pick < 7) op.const_value = $urandom_range(32'h00ffffff);
      end
      return op;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Presents one item from a falling edge, holds it until taken, then records
   // what should come out for it.
   task automatic send_item(input a32enc_pkg::req_item_type op, input logic fixed_exp,
                            input logic [31:0] word, input logic error);
      while (idle_enable && $urandom_range(99) < 23) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid            <= 1'b1;
      req_ch.req_type         <= op.req_type;
      req_ch.reg_first        <= op.reg_first;
      req_ch.reg_second       <= op.reg_second;
      req_ch.reg_third        <= op.reg_third;
      req_ch.operand_is_const <= op.operand_is_const;
      req_ch.has_offset       <= op.has_offset;
      req_ch.const_value      <= op.const_value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // accepted at this edge
      if (fixed_exp) expected_words.push_back('{word, 1'b1, error});
      else           predict_a32_words(op);
      @(negedge clock);
   endtask

   // Receiver back-pressure, changed on falling edges only.
   always @(negedge clock)
      rsp_ch.ready <= !idle_enable || ($urandom_range(99) >= 23);

   // Response checker: every taken word against the oldest expectation.
   always @(posedge clock) begin : check_words
      exp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.machine_word, 32'd0);
         end else begin
            want = expected_words.pop_front();
            if (rsp_ch.machine_word !== want.word)
               report_mismatch("machine_word", rsp_ch.machine_word, want.word);
            if (rsp_ch.last_word !== want.last)
               report_mismatch("last_word", {31'd0, rsp_ch.last_word}, {31'd0, want.last});
            if (rsp_ch.encode_error !== want.error)
               report_mismatch("encode_error", {31'd0, rsp_ch.encode_error},
                               {31'd0, want.error});
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      reset                   = 1'b1;
      req_ch.valid            = 1'b0;
      req_ch.req_type         = '0;
      req_ch.reg_first        = '0;
      req_ch.reg_second       = '0;
      req_ch.reg_third        = '0;
      req_ch.operand_is_const = 1'b0;
      req_ch.has_offset       = 1'b0;
      req_ch.const_value      = '0;
      rsp_ch.ready            = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_item(directed_rows[i].op, directed_rows[i].fixed_exp,
                   directed_rows[i].word, directed_rows[i].error);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a stretch at full rate on both sides
         idle_enable = !(n >= QUIET_FIRST && n <= QUIET_LAST);
         send_item(random_operation(), 1'b0, 32'd0, 1'b0);
      end
      idle_enable = 1'b1;
      req_ch.valid <= 1'b0;

      // drain, then a few more edges to catch stray words
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && expected_words.size() == 0)
         $display("arm32_instruction_encoder test passed");
      else
         $display("arm32_instruction_encoder test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("arm32_instruction_encoder test failed");
      $finish;
   end

endmodule

### arm32_instruction_encoder.f
+incdir+rtl/core
rtl/core/a32enc_pkg.sv
rtl/core/a32enc_if.sv
rtl/core/a32enc_rotimm.sv
rtl/core/a32enc_core.sv
rtl/core/arm32_instruction_encoder.sv
rtl/core/a32enc_checker.sv
bench/arm32_instruction_encoder_tb.sv
